/* design/gdmf_pkg.sv */
// Package for the greedy DFS max-flow block: constants, payload structs,
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package gdmf_pkg;
  localparam int MaxNodesDef = 8;
  localparam int CapBitsDef  = 16;
  localparam int SLOTS = 8;
  localparam int CELLS = 64;
  localparam int RES_W = CapBitsDef + 4;   // residual with reverse-flow headroom
  localparam int TOT_W = 20;

  localparam logic [0:0] REG_SOURCE = 1'b0;
  localparam logic [0:0] REG_SINK   = 1'b1;

  typedef struct packed {
    logic [2:0]  from_node;
    logic [2:0]  to_node;
    logic [15:0] capacity;
    logic        last_edge;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  edge_from;
    logic [2:0]  edge_to;
    logic [15:0] edge_flow;
    logic [18:0] total_flow;
    logic        last;
  } out_item_t;

  // commands from controller to datapath; memory reads are registered,
  // so a read command's data is used in the next cycle
  typedef struct packed {
    logic load;       // store input edge
    logic init_cell;  // read cap[cnt]; next cycle residual <= present ? cap : 0
    logic clr_total;
    logic start_path; // visited/stack/cur <= source
    logic scan_cell;  // read residual[cur][cnt]; next cycle test as candidate
    logic clr_best;
    logic step;       // push best or pop
    logic neck_cell;  // read residual of path edge cnt; next cycle fold into bottleneck
    logic rd_fwd;     // read residual of path edge cnt
    logic rd_rev;     // read residual of reverse of path edge cnt
    logic sub_neck;   // write back last read residual minus neck
    logic add_neck;   // write back last read residual plus neck
    logic add_total;
    logic rd_cell;    // load output register from cell cnt
    logic clr_present;
  } cmd_t;

  typedef struct packed {
    logic at_sink;
    logic fail;       // dead end at the source
    logic neck_zero;
    logic [3:0] plen;
    logic present;    // present bit of cell cnt
    logic bad_ends;   // source/sink out of range or equal
  } stat_t;
endpackage

/* design/greedy_dfs_max_flow.sv */
// Top level of the greedy DFS max-flow block: APB registers, controller
// and datapath. Depends on gdmf_pkg, gdmf_ctrl, gdmf_datapath.
//
// Usage: edges arrive on the in channel (valid/ready), one per cycle. An
// edge with last_edge set starts the computation; in_ready stays low
// until every result item has been handed over. Results leave on the out
// channel, one per present edge in row-major order, last set on the final.
// After the last edge the residual of every cell is set up; then each
// search starts, and each search step checks for the sink, reads the 8
// neighbors, lets the last candidate settle and steps. Per path found
// it checks, folds path edges into the bottleneck, decides, and updates
// each hop by reading forward and reverse residuals and writing both.
// The report sweep walks every cell, reading and emitting present ones,
// then waits out the final item. Each store has one registered read port.
// A stalled receiver holds the sweep; the held item keeps its payload.
// Synchronous reset clears control, the present map and registers
// source_node=0, sink_node=7.
`timescale 1ns / 1ps
module greedy_dfs_max_flow import gdmf_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDef,
  parameter int CAP_BITS  = CapBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [2:0] src, snk;
  cmd_t cmd;
  stat_t st;
  logic [5:0] cnt;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      src <= 3'd0;
      snk <= 3'd7;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[2])
        REG_SOURCE: src <= pwdata[2:0];
        REG_SINK:   snk <= pwdata[2:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_SOURCE: prdata = {29'd0, src};
      REG_SINK:   prdata = {29'd0, snk};
      default: prdata = '0;
    endcase
  end

  gdmf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_last(in_data.last_edge),
    .out_valid, .out_ready, .st, .cmd, .cnt
  );

  gdmf_datapath #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS)) u_dp (
    .clk, .rst, .cmd, .cnt, .din(in_data), .src, .snk, .st, .dout(out_data)
  );
endmodule

/* design/gdmf_datapath.sv */
// Datapath: capacity/residual memories, DFS stack, bottleneck and totals.
// Depends on gdmf_pkg.
`timescale 1ns / 1ps
module gdmf_datapath import gdmf_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDef,
  parameter int CAP_BITS  = CapBitsDef
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic [5:0] cnt,
  input  in_item_t   din,
  input  logic [2:0] src,
  input  logic [2:0] snk,
  output stat_t      st,
  output out_item_t  dout
);
  localparam int RW = CAP_BITS + 4;

  logic [CAP_BITS-1:0] cap_mem [CELLS];
  logic [RW-1:0]       res_mem [CELLS];
  logic [CELLS-1:0]    present;
  logic [7:0]          visited;
  logic [2:0]          stack [SLOTS];
  logic [3:0]          plen;
  logic [2:0]          cur;
  logic [RW-1:0]       best;
  logic [2:0]          pick;
  logic                found;
  logic [RW-1:0]       neck;
  logic [TOT_W-1:0]    total;

  logic [2:0] col;
  logic [2:0] pa, pb;
  logic [5:0] a_fwd, a_rev;
  logic       load_ok;
  logic [5:0] raddr;
  logic [RW-1:0]       res_q;
  logic [CAP_BITS-1:0] cap_q;
  logic [5:0]          raddr_q;
  logic                init_q, scan_q, neck_q;
  logic [CELLS-1:0]    above;

  assign col = cnt[2:0];
  assign pa = stack[cnt[2:0]];
  assign pb = stack[cnt[2:0] + 3'd1];
  assign a_fwd = {pa, pb};
  assign a_rev = {pb, pa};
  assign load_ok = ({1'b0, din.from_node} < 4'(MAX_NODES)) &&
                   ({1'b0, din.to_node} < 4'(MAX_NODES));

  // residual address mux: one registered read, one write per cycle
  always_comb begin
    raddr = cnt;
    if (cmd.scan_cell) raddr = {cur, col};
    else if (cmd.neck_cell || cmd.rd_fwd) raddr = a_fwd;
    else if (cmd.rd_rev) raddr = a_rev;
  end

  // capacity memory, read at cnt every cycle
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok)
      cap_mem[{din.from_node, din.to_node}] <= CAP_BITS'(din.capacity);
    cap_q <= cap_mem[cnt];
  end

  // residual memory; writes go to the address read in the previous cycle
  always_ff @(posedge clk) begin
    if (init_q)
      res_mem[raddr_q] <= present[raddr_q] ? RW'(cap_q) : '0;
    else if (cmd.sub_neck)
      res_mem[raddr_q] <= res_q - neck;
    else if (cmd.add_neck)
      res_mem[raddr_q] <= res_q + neck;
    res_q <= res_mem[raddr];
  end

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      init_q  <= 1'b0;
      scan_q  <= 1'b0;
      neck_q  <= 1'b0;
      raddr_q <= '0;
    end else begin
      init_q  <= cmd.init_cell;
      scan_q  <= cmd.scan_cell;
      neck_q  <= cmd.neck_cell;
      raddr_q <= raddr;
    end
  end

  // present map
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_present) begin
      present <= '0;
    end else if (cmd.load && load_ok) begin
      present[{din.from_node, din.to_node}] <= 1'b1;
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      plen <= '0;
      cur <= '0;
      found <= 1'b0;
      best <= '0;
      pick <= '0;
      neck <= '0;
      total <= '0;
    end else begin
      if (cmd.clr_total) total <= '0;
      if (cmd.add_total) total <= total + TOT_W'(neck);
      if (cmd.start_path) begin
        visited <= 8'(1) << src;
        stack[0] <= src;
        plen <= 4'd1;
        cur <= src;
        neck <= '1;
      end
      if (cmd.clr_best) begin
        best <= '0;
        found <= 1'b0;
      end
      if (scan_q && {1'b0, raddr_q[2:0]} < 4'(MAX_NODES) && res_q > best &&
          !visited[raddr_q[2:0]]) begin
        best <= res_q;
        pick <= raddr_q[2:0];
        found <= 1'b1;
      end
      if (cmd.step) begin
        if (found && plen < 4'(SLOTS)) begin
          stack[plen[2:0]] <= pick;
          plen <= plen + 4'd1;
          visited[pick] <= 1'b1;
          cur <= pick;
        end else if (plen > 4'd1) begin
          plen <= plen - 4'd1;
          cur <= stack[plen[2:0] - 3'd2];
        end
      end
      if (neck_q && res_q < neck) neck <= res_q;
    end
  end

  assign st.at_sink   = (cur == snk);
  assign st.fail      = !(found && plen < 4'(SLOTS)) && plen <= 4'd1;
  assign st.neck_zero = (neck == '0);
  assign st.plen      = plen;
  assign st.present   = present[cnt];
  assign st.bad_ends  = ({1'b0, src} >= 4'(MAX_NODES)) || ({1'b0, snk} >= 4'(MAX_NODES)) ||
                        (src == snk);

  // cells above cnt; none present means this is the final item
  assign above = present >> cnt;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.rd_cell) begin
      dout.edge_from  <= cnt[5:3];
      dout.edge_to    <= cnt[2:0];
      dout.edge_flow  <= (RW'(cap_q) > res_q) ? 16'(RW'(cap_q) - res_q) : '0;
      dout.total_flow <= total[18:0];
      dout.last       <= (above[CELLS-1:1] == '0);
    end
  end
endmodule

/* design/gdmf_ctrl.sv */
// Controller state machine sequencing load, search, augment and report.
// Depends on gdmf_pkg.
`timescale 1ns / 1ps
module gdmf_ctrl import gdmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  input  stat_t      st,
  output cmd_t       cmd,
  output logic [5:0] cnt
);
  typedef enum logic [13:0] {
    S_LOAD   = 14'b00000000000001,
    S_INIT   = 14'b00000000000010,
    S_START  = 14'b00000000000100,
    S_CHECK  = 14'b00000000001000,
    S_SCAN   = 14'b00000000010000,
    S_STEP   = 14'b00000000100000,
    S_NECK   = 14'b00000001000000,
    S_NGATE  = 14'b00000010000000,
    S_AFWD   = 14'b00000100000000,
    S_AREV   = 14'b00001000000000,
    S_AADD   = 14'b00010000000000,
    S_FIND   = 14'b00100000000000,
    S_FOUT   = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic [5:0] cnt_next;
  logic ov, ov_next;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = ov;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ov_next = ov;
    cmd = '0;
    case (state)
      S_LOAD: begin
        if (ov && out_ready) ov_next = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = S_INIT;
            cnt_next = '0;
          end
        end
      end
      S_INIT: begin
        cmd.init_cell = 1'b1;
        cmd.clr_total = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) state_next = st.bad_ends ? S_FIND : S_START;
      end
      S_START: begin
        cmd.start_path = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.clr_best = 1'b1;
        cnt_next = '0;
        state_next = st.at_sink ? S_NECK : S_SCAN;
      end
      S_SCAN: begin
        // eight reads, then a pass with no read for the last candidate to settle
        cmd.scan_cell = !cnt[3];
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd8) state_next = S_STEP;
      end
      S_STEP: begin
        if (st.fail) begin
          state_next = S_FIND;
          cnt_next = '0;
        end else begin
          cmd.step = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_NECK: begin
        if (cnt + 6'd1 < 6'(st.plen)) begin
          cmd.neck_cell = 1'b1;
          cnt_next = cnt + 6'd1;
        end else begin
          cnt_next = '0;
          state_next = S_NGATE;
        end
      end
      S_NGATE: begin
        if (st.plen < 4'd2 || st.neck_zero) begin
          state_next = S_FIND;
        end else begin
          cmd.add_total = 1'b1;
          state_next = S_AFWD;
        end
      end
      S_AFWD: begin
        cmd.rd_fwd = 1'b1;
        state_next = S_AREV;
      end
      S_AREV: begin
        cmd.sub_neck = 1'b1;
        cmd.rd_rev = 1'b1;
        state_next = S_AADD;
      end
      S_AADD: begin
        cmd.add_neck = 1'b1;
        cnt_next = cnt + 6'd1;
        state_next = (cnt + 6'd2 < 6'(st.plen)) ? S_AFWD : S_START;
      end
      S_FIND: begin
        // walk cells; a present one is read, then emitted from S_FOUT
        if (ov && out_ready) ov_next = 1'b0;
        if (st.present) begin
          state_next = S_FOUT;
        end else begin
          cnt_next = cnt + 6'd1;
          if (cnt == 6'd63) begin
            cmd.clr_present = 1'b1;
            state_next = S_EMIT;
          end
        end
      end
      S_FOUT: begin
        if (!ov || out_ready) begin
          cmd.rd_cell = 1'b1;
          ov_next = 1'b1;
          cnt_next = cnt + 6'd1;
          if (cnt == 6'd63) begin
            cmd.clr_present = 1'b1;
            state_next = S_EMIT;
          end else begin
            state_next = S_FIND;
          end
        end
      end
      S_EMIT: begin
        // wait out the final item before taking edges again
        if (!ov || out_ready) begin
          ov_next = 1'b0;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt <= '0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      ov <= ov_next;
    end
  end
endmodule

/* design/gdmf_checker.sv */
// Port-level checker for greedy_dfs_max_flow, bound to the top level.
// Depends on gdmf_pkg.
`timescale 1ns / 1ps
module gdmf_props import gdmf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed");
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("result pending while taking edges");
  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last ##1 out_valid
    |-> {out_data.edge_from, out_data.edge_to} >
        $past({out_data.edge_from, out_data.edge_to}) || $past(!out_ready) ||
        !$past(out_valid && out_ready))
    else $error("edges out of order");
  a_total_same: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last ##1 out_valid
    |-> out_data.total_flow == $past(out_data.total_flow))
    else $error("total changed within a run");
endmodule

bind greedy_dfs_max_flow gdmf_props u_chk (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .out_data, .pready
);
